@@ design/ascon_pkg.sv @@
// ----------------------------------------------------------------------------
// ascon_pkg
// Shared types, constants and helper functions for the Ascon hash/XOF core.
// ----------------------------------------------------------------------------
`default_nettype none

package ascon_pkg;

    // Sponge geometry
    localparam int LANES       = 5;
    localparam int LANE_W      = 64;
    localparam int PERM_ROUNDS = 12;
    localparam int ROUND_W     = 4;
    localparam int ROUND_BASE  = 12 - PERM_ROUNDS;
    localparam int HASH_WORDS  = 4;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_ADDR_W-1:0] CFG_XOF_MODE  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_OUT_WORDS = 2'd1;
    localparam logic [CFG_DATA_W-1:0] OUT_WORDS_RST = 7'd4;

    // Initial values of lane 0 for each mode
    localparam logic [LANE_W-1:0] IV_HASH = 64'h0040_0c00_0000_0100;
    localparam logic [LANE_W-1:0] IV_XOF  = 64'h0040_0c00_0000_0000;
    localparam logic [7:0]        PAD_BYTE = 8'h80;

    typedef logic [LANES-1:0][LANE_W-1:0] t_lanes;

    // Rotate right by a constant amount
    function automatic logic [LANE_W-1:0] rotr(input logic [LANE_W-1:0] v,
                                               input int unsigned n);
        return (v >> n) | (v << (LANE_W - n));
    endfunction

    // Round constant table
    function automatic logic [7:0] round_const(input logic [ROUND_W-1:0] r);
        logic [7:0] rc;
        case (r)
            4'd0:    rc = 8'hf0;
            4'd1:    rc = 8'he1;
            4'd2:    rc = 8'hd2;
            4'd3:    rc = 8'hc3;
            4'd4:    rc = 8'hb4;
            4'd5:    rc = 8'ha5;
            4'd6:    rc = 8'h96;
            4'd7:    rc = 8'h87;
            4'd8:    rc = 8'h78;
            4'd9:    rc = 8'h69;
            4'd10:   rc = 8'h5a;
            4'd11:   rc = 8'h4b;
            default: rc = 8'h00;
        endcase
        return rc;
    endfunction

    // Word to XOR into lane 0: a full word, or kept bytes plus the pad byte
    function automatic logic [LANE_W-1:0] absorb_word(input logic [LANE_W-1:0] w,
                                                      input logic [2:0]        vb,
                                                      input logic              last);
        logic [LANE_W-1:0] res;
        res = w;
        if (last) begin
            for (int j = 0; j < 8; j++) begin
                if (j < int'(vb)) begin
                    res[LANE_W-1-8*j -: 8] = w[LANE_W-1-8*j -: 8];
                end else if (j == int'(vb)) begin
                    res[LANE_W-1-8*j -: 8] = PAD_BYTE;
                end else begin
                    res[LANE_W-1-8*j -: 8] = 8'h00;
                end
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ design/ascon_if.sv @@
// ----------------------------------------------------------------------------
// ascon_if
// Valid/ready channel interfaces: message input, digest output, config writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ascon_msg_if;
    logic        valid;
    logic        ready;
    logic [63:0] msg_word;
    logic [2:0]  valid_bytes;
    logic        last;

    modport source (output valid, msg_word, valid_bytes, last, input ready);
    modport sink   (input valid, msg_word, valid_bytes, last, output ready);
endinterface

interface ascon_dig_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic        last_word;

    modport source (output valid, digest_word, last_word, input ready);
    modport sink   (input valid, digest_word, last_word, output ready);
endinterface

interface ascon_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] addr;
    logic [6:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

@@ design/ascon_hash_xof_sponge_core.sv @@
// ----------------------------------------------------------------------------
// ascon_hash_xof_sponge_core
// Ascon-Hash / Ascon-XOF sponge, 64-bit rate, one permutation round per cycle.
// ----------------------------------------------------------------------------
//  channel | dir | payload                          | transfer when
//  i_cfg   | in  | addr[1:0], data[6:0]             | valid & ready (ready = 1)
//  i_msg   | in  | msg_word[63:0], valid_bytes, last| valid & ready
//  o_dig   | out | digest_word[63:0], last_word     | valid & ready
//
//  Every message item takes one transfer plus the 12 rounds of the single
//  round unit. The first item of a message adds the IV permutation before
//  its own. Between digest words the round unit runs a full permutation.
//  i_msg.ready is high only while the core is idle; a stalled digest word
//  holds until taken. Reset (synchronous, active low) closes any message.
// ----------------------------------------------------------------------------
`default_nettype none

module ascon_hash_xof_sponge_core #(
    parameter int MAX_OUT_WORDS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ascon_cfg_if.sink          i_cfg,
    ascon_msg_if.sink          i_msg,
    ascon_dig_if.source        o_dig
);
    import ascon_pkg::*;

    localparam int CNT_W = (MAX_OUT_WORDS > 1) ? $clog2(MAX_OUT_WORDS) : 1;
    localparam logic [CFG_DATA_W-1:0] MAX_WORDS = CFG_DATA_W'(MAX_OUT_WORDS);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_PERM = 3'b010,
        ST_OUT  = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic                  r_open, n_open;
    logic                  r_absorb_pend, n_absorb_pend;
    logic                  r_last_item, n_last_item;
    logic [ROUND_W-1:0]    r_round, n_round;
    logic [CNT_W-1:0]      r_left, n_left;
    t_lanes                r_lanes, n_lanes;
    logic [LANE_W-1:0]     r_word, n_word;
    logic                  r_xof;
    logic [CFG_DATA_W-1:0] r_out_words;

    t_lanes                w_round_out;
    logic [LANE_W-1:0]     w_absorb;
    logic [CFG_DATA_W-1:0] w_nwords;
    logic [CNT_W-1:0]      w_left_init;
    logic                  w_msg_fire;
    logic                  w_dig_fire;

    // Shared round unit
    ascon_round u_round (
        .i_lanes (r_lanes),
        .i_rc    (round_const(ROUND_W'(ROUND_BASE) + r_round)),
        .o_lanes (w_round_out)
    );

    // Handshakes
    assign i_cfg.ready = 1'b1;
    assign i_msg.ready = (r_state == ST_IDLE);
    assign w_msg_fire  = i_msg.valid && (r_state == ST_IDLE);
    assign w_dig_fire  = o_dig.ready && (r_state == ST_OUT);

    assign o_dig.valid       = (r_state == ST_OUT);
    assign o_dig.digest_word = r_lanes[0];
    assign o_dig.last_word   = (r_left == '0);

    // Digest word count: XOF count clamped to 1..MAX_OUT_WORDS, HASH_WORDS in hash mode
    always_comb begin
        if (r_out_words == '0) begin
            w_nwords = CFG_DATA_W'(1);
        end else if (r_out_words > MAX_WORDS) begin
            w_nwords = MAX_WORDS;
        end else begin
            w_nwords = r_out_words;
        end
        if (r_xof) begin
            w_left_init = CNT_W'(w_nwords - CFG_DATA_W'(1));
        end else begin
            w_left_init = CNT_W'(HASH_WORDS - 1);
        end
    end

    assign w_absorb = absorb_word(i_msg.msg_word, i_msg.valid_bytes, i_msg.last);

    // Sequencer
    always_comb begin
        n_state       = r_state;
        n_open        = r_open;
        n_absorb_pend = r_absorb_pend;
        n_last_item   = r_last_item;
        n_round       = r_round;
        n_left        = r_left;
        n_lanes       = r_lanes;
        n_word        = r_word;
        unique case (r_state)
            ST_IDLE: begin
                if (w_msg_fire) begin
                    n_word      = w_absorb;
                    n_last_item = i_msg.last;
                    n_round     = '0;
                    n_left      = w_left_init;
                    n_state     = ST_PERM;
                    if (!r_open) begin
                        // new message: load IV, absorb after first permutation
                        n_lanes[0]    = r_xof ? IV_XOF : IV_HASH;
                        n_lanes[1]    = '0;
                        n_lanes[2]    = '0;
                        n_lanes[3]    = '0;
                        n_lanes[4]    = '0;
                        n_absorb_pend = 1'b1;
                        n_open        = 1'b1;
                    end else begin
                        n_lanes[0]    = r_lanes[0] ^ w_absorb;
                        n_absorb_pend = 1'b0;
                    end
                end
            end
            ST_PERM: begin
                n_lanes = w_round_out;
                n_round = r_round + ROUND_W'(1);
                if (r_round == ROUND_W'(PERM_ROUNDS - 1)) begin
                    n_round = '0;
                    if (r_absorb_pend) begin
                        n_lanes[0]    = w_round_out[0] ^ r_word;
                        n_absorb_pend = 1'b0;
                    end else if (r_last_item) begin
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_OUT: begin
                if (w_dig_fire) begin
                    if (r_left == '0) begin
                        n_state     = ST_IDLE;
                        n_open      = 1'b0;
                        n_last_item = 1'b0;
                    end else begin
                        n_left  = r_left - CNT_W'(1);
                        n_state = ST_PERM;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_open        <= 1'b0;
            r_absorb_pend <= 1'b0;
            r_last_item   <= 1'b0;
            r_round       <= '0;
            r_left        <= '0;
        end else begin
            r_state       <= n_state;
            r_open        <= n_open;
            r_absorb_pend <= n_absorb_pend;
            r_last_item   <= n_last_item;
            r_round       <= n_round;
            r_left        <= n_left;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_lanes <= n_lanes;
        r_word  <= n_word;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xof       <= 1'b0;
            r_out_words <= OUT_WORDS_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.addr)
                CFG_XOF_MODE:  r_xof       <= i_cfg.data[0];
                CFG_OUT_WORDS: r_out_words <= i_cfg.data;
                default:       ;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ design/ascon_round.sv @@
// ----------------------------------------------------------------------------
// ascon_round
// One round of Ascon-p: constant addition, S-box layer, linear diffusion.
// ----------------------------------------------------------------------------
`default_nettype none

module ascon_round (
    input  ascon_pkg::t_lanes i_lanes,
    input  logic [7:0]        i_rc,
    output ascon_pkg::t_lanes o_lanes
);
    import ascon_pkg::*;

    logic [LANE_W-1:0] a, b, c, d, e;
    logic [LANE_W-1:0] t0, t1, t2, t3, t4;

    always_comb begin
        a = i_lanes[0];
        b = i_lanes[1];
        c = i_lanes[2] ^ {56'd0, i_rc};
        d = i_lanes[3];
        e = i_lanes[4];

        // bitsliced 5-bit S-box
        a = a ^ e;
        e = e ^ d;
        c = c ^ b;
        t0 = ~a & b;
        t1 = ~b & c;
        t2 = ~c & d;
        t3 = ~d & e;
        t4 = ~e & a;
        a = a ^ t1;
        b = b ^ t2;
        c = c ^ t3;
        d = d ^ t4;
        e = e ^ t0;
        b = b ^ a;
        a = a ^ e;
        d = d ^ c;
        c = ~c;

        // linear layer
        o_lanes[0] = a ^ rotr(a, 19) ^ rotr(a, 28);
        o_lanes[1] = b ^ rotr(b, 61) ^ rotr(b, 39);
        o_lanes[2] = c ^ rotr(c, 1)  ^ rotr(c, 6);
        o_lanes[3] = d ^ rotr(d, 10) ^ rotr(d, 17);
        o_lanes[4] = e ^ rotr(e, 7)  ^ rotr(e, 41);
    end

endmodule

`default_nettype wire

@@ design/ascon_checker.sv @@
// ----------------------------------------------------------------------------
// ascon_checker
// Port-level checks of the sponge core's sequencing, bound to the sponge core.
// ----------------------------------------------------------------------------
`default_nettype none

module ascon_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_msg_valid,
    input logic        i_msg_ready,
    input logic        i_dig_valid,
    input logic        i_dig_ready,
    input logic [63:0] i_dig_word,
    input logic        i_dig_last
);

    // core never takes input while a digest word is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_msg_ready |-> !i_dig_valid)
        else $error("input ready while digest word pending");

    // an accepted item keeps the core busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_msg_valid && i_msg_ready) |=> !i_msg_ready)
        else $error("input ready right after a transfer");

    // a permutation or idle cycle follows every digest transfer
    a_gap_after_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_dig_valid && i_dig_ready) |=> !i_dig_valid)
        else $error("digest words back to back");

    // stalled digest word holds
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_dig_valid && !i_dig_ready) |=>
            (i_dig_valid && $stable(i_dig_word) && $stable(i_dig_last)))
        else $error("digest word changed under stall");

endmodule

bind ascon_hash_xof_sponge_core ascon_checker u_ascon_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_msg_valid (i_msg.valid),
    .i_msg_ready (i_msg.ready),
    .i_dig_valid (o_dig.valid),
    .i_dig_ready (o_dig.ready),
    .i_dig_word  (o_dig.digest_word),
    .i_dig_last  (o_dig.last_word)
);

`default_nettype wire
